>>> sv/rate_limited_gimbal_mixer_core_assert.svh
// Assertion macros for the gimbal mixer port checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef RATE_LIMITED_GIMBAL_MIXER_CORE_ASSERT_SVH
`define RATE_LIMITED_GIMBAL_MIXER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RLGM_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlgm checker: property failed");

// Consequent checked in the cycle after the antecedent.
`define RLGM_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlgm checker: property failed");

`endif

>>> sv/rlgm_pkg.sv
// Shared types, constants and helper functions for the gimbal mixer.
// No dependencies; used by every other file of the block except the assertion header.
`default_nettype none

package rlgm_pkg;

	// Widths
	localparam int CMD_W     = 16;
	localparam int NUM_SHIFT = 33;
	localparam int NUM_W     = CMD_W + NUM_SHIFT;   // |rate| << 33
	localparam int DEN_W     = 31;                  // gain * |cmd|
	localparam int Q_W       = 18;                  // quotient bits kept
	localparam int F_W       = 18;                  // factor, Q.14, -8..1
	localparam int TERM_W    = 21;                  // one axis term
	localparam int ENG_W     = 3;
	localparam int LANE_LAT  = Q_W + 7;             // lane register stages

	localparam logic [ENG_W-1:0] LAST_ENGINE = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_STAGE_MODE = 2'd0;
	localparam logic [1:0] CFG_PITCH_EN   = 2'd1;
	localparam logic [1:0] CFG_YAW_EN     = 2'd2;

	// Fixed-point constants
	localparam logic [14:0] GAIN_0175  = 15'd11469;
	localparam logic [14:0] GAIN_035   = 15'd22938;
	localparam logic [15:0] WEIGHT_009 = 16'd5898;
	localparam logic [15:0] WEIGHT_060 = 16'd39322;
	localparam logic signed [18:0] DAMP_24  = 19'sd157286;
	localparam logic signed [18:0] DAMP_285 = 19'sd186778;
	localparam logic signed [18:0] DAMP_19  = 19'sd124518;
	localparam logic signed [18:0] DAMP_198 = 19'sd129761;
	localparam logic signed [F_W-1:0] ONE_Q14    = 18'sd16384;
	localparam logic signed [F_W-1:0] FACTOR_MIN = 18'sh20000;   // -8.0
	localparam logic [Q_W-1:0] Q_MAX = 18'd147456;               // 1.0 - (-8.0)

	typedef enum logic [1:0] {
		MODE_FIRST  = 2'd0,
		MODE_UPPER  = 2'd1,
		MODE_SINGLE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		RULE_NONE     = 2'd0,
		RULE_SAME     = 2'd1,
		RULE_OPPOSITE = 2'd2
	} rule_t;

	typedef enum logic [1:0] {
		ROLL_NONE = 2'd0,
		ROLL_ADD  = 2'd1,
		ROLL_SUB  = 2'd2
	} roll_op_t;

	typedef struct packed {
		logic signed [CMD_W-1:0] pitch_cmd;
		logic signed [CMD_W-1:0] yaw_cmd;
		logic signed [CMD_W-1:0] roll_cmd;
		logic signed [CMD_W-1:0] rate_pitch;
		logic signed [CMD_W-1:0] rate_yaw;
		logic signed [CMD_W-1:0] rate_roll;
	} item_t;

	typedef struct packed {
		logic [ENG_W-1:0]        engine_index;
		logic signed [15:0]      deflect_x;
		logic signed [15:0]      deflect_y;
		logic                    last_engine;
	} result_t;

	// Per-axis constants chosen at entry
	typedef struct packed {
		logic [14:0]        gain;
		rule_t              rule;
		logic [15:0]        weight;
		logic signed [18:0] damp;
	} lane_cfg_t;

	// Travels alongside the divider stages
	typedef struct packed {
		logic signed [CMD_W-1:0] cmd;
		logic signed [CMD_W-1:0] rate;
		logic                    forced;
		lane_cfg_t               cfg;
	} lane_side_t;

	// Lane outputs handed to the mixing stage
	typedef struct packed {
		mode_t                    mode;
		logic signed [TERM_W-1:0] pt;
		logic signed [TERM_W-1:0] yt;
		logic signed [TERM_W-1:0] rt;
	} mix_in_t;

	// Roll contribution per engine and mode
	function automatic roll_op_t roll_op(input mode_t mode, input logic [ENG_W-1:0] eng);
		roll_op_t op;
		op = ROLL_NONE;
		case (mode)
			MODE_FIRST: begin
				case (eng) inside
					3'd0, 3'd3: op = ROLL_ADD;
					3'd1, 3'd2: op = ROLL_SUB;
					default:    op = ROLL_NONE;
				endcase
			end
			MODE_UPPER: begin
				case (eng) inside
					3'd1, 3'd3: op = ROLL_ADD;
					3'd0, 3'd2: op = ROLL_SUB;
					default:    op = ROLL_NONE;
				endcase
			end
			default: op = ROLL_NONE;
		endcase
		return op;
	endfunction

	// Saturate a summed term to signed Q2.14
	function automatic logic signed [15:0] sat16(input logic signed [TERM_W:0] v);
		logic signed [TERM_W:0] hi;
		logic signed [TERM_W:0] lo;
		logic signed [15:0]     r;
		hi = (TERM_W+1)'(32767);
		lo = (TERM_W+1)'(-32768);
		if (v > hi) begin
			r = 16'sh7fff;
		end else if (v < lo) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/rlgm_div.sv
// Pipelined restoring divider: one quotient bit per stage plus an overflow check.
// Depends on rlgm_pkg for widths and the side-band type.
`default_nettype none

module rlgm_div (
	input  logic                          clk,
	input  logic                          adv,
	input  logic [rlgm_pkg::NUM_W-1:0]    num,
	input  logic [rlgm_pkg::DEN_W-1:0]    den,
	input  rlgm_pkg::lane_side_t          side_in,
	output logic [rlgm_pkg::Q_W-1:0]      quot,
	output logic                          ovf,
	output rlgm_pkg::lane_side_t          side_out
);

	localparam int NW = rlgm_pkg::NUM_W;
	localparam int DW = rlgm_pkg::DEN_W;
	localparam int QW = rlgm_pkg::Q_W;

	logic [NW-1:0]            rem_s  [0:QW-1];
	logic [DW-1:0]            den_s  [0:QW-1];
	logic [QW-1:0]            quo_s  [0:QW];
	logic                     ovf_s  [0:QW];
	rlgm_pkg::lane_side_t     side_s [0:QW];

	logic [NW-1:0] den_top;
	logic [NW-1:0] trial [1:QW];
	logic [1:QW]   fits;

	// quotient must fit in QW bits, else the factor saturates anyway
	assign den_top = NW'(den) << QW;

	always_comb begin
		for (int k = 1; k <= QW; k++) begin
			trial[k] = NW'(den_s[k-1]) << (QW - k);
			fits[k]  = rem_s[k-1] >= trial[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= num;
			den_s[0]  <= den;
			quo_s[0]  <= '0;
			ovf_s[0]  <= num >= den_top;
			side_s[0] <= side_in;
			for (int k = 1; k < QW; k++) begin
				rem_s[k] <= fits[k] ? (rem_s[k-1] - trial[k]) : rem_s[k-1];
				den_s[k] <= den_s[k-1];
			end
			for (int k = 1; k <= QW; k++) begin
				quo_s[k]  <= {quo_s[k-1][QW-2:0], fits[k]};
				ovf_s[k]  <= ovf_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign quot     = quo_s[QW];
	assign ovf      = ovf_s[QW];
	assign side_out = side_s[QW];

endmodule

`default_nettype wire

>>> sv/rlgm_lane.sv
// One axis lane: rate-limiting factor via pipelined divide, command or damping term.
// Depends on rlgm_pkg and rlgm_div.
`default_nettype none

module rlgm_lane (
	input  logic                                  clk,
	input  logic                                  adv,
	input  logic signed [rlgm_pkg::CMD_W-1:0]     cmd,
	input  logic signed [rlgm_pkg::CMD_W-1:0]     rate,
	input  rlgm_pkg::lane_cfg_t                   cfg,
	output logic signed [rlgm_pkg::TERM_W-1:0]    term
);

	localparam int CW = rlgm_pkg::CMD_W;
	localparam int NW = rlgm_pkg::NUM_W;
	localparam int DW = rlgm_pkg::DEN_W;
	localparam int QW = rlgm_pkg::Q_W;
	localparam int FW = rlgm_pkg::F_W;
	localparam int TW = rlgm_pkg::TERM_W;
	localparam logic signed [51:0] CMD_HALF  = 52'sd1 <<< 30;
	localparam logic signed [35:0] DAMP_HALF = 36'sd1 <<< 13;

	logic [CW-1:0] cmd_mag;
	logic [CW-1:0] rate_mag;
	logic          cmd_pos, cmd_neg, rate_pos, rate_neg;
	logic          forced;

	always_comb begin
		cmd_neg  = cmd[CW-1];
		cmd_pos  = !cmd[CW-1] && (cmd != '0);
		rate_neg = rate[CW-1];
		rate_pos = !rate[CW-1] && (rate != '0);
		cmd_mag  = cmd_neg ? CW'(-cmd) : CW'(cmd);
		rate_mag = rate_neg ? CW'(-rate) : CW'(rate);
		case (cfg.rule)
			rlgm_pkg::RULE_SAME:     forced = (cmd_pos && rate_pos) || (cmd_neg && rate_neg);
			rlgm_pkg::RULE_OPPOSITE: forced = (cmd_pos && rate_neg) || (cmd_neg && rate_pos);
			default:                 forced = 1'b0;
		endcase
	end

	// s1: magnitudes and sign rule
	logic [CW-1:0]         cmd_mag_s1, rate_mag_s1;
	rlgm_pkg::lane_side_t  side_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_mag_s1     <= cmd_mag;
			rate_mag_s1    <= rate_mag;
			side_s1.cmd    <= cmd;
			side_s1.rate   <= rate;
			side_s1.forced <= forced;
			side_s1.cfg    <= cfg;
		end
	end

	// s2: divisor gain * |cmd|, dividend |rate| << 33
	logic [NW-1:0]         num_s2;
	logic [DW-1:0]         den_s2;
	rlgm_pkg::lane_side_t  side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2  <= {rate_mag_s1, {rlgm_pkg::NUM_SHIFT{1'b0}}};
			den_s2  <= DW'(cmd_mag_s1) * DW'(side_s1.cfg.gain);
			side_s2 <= side_s1;
		end
	end

	logic [QW-1:0]         div_q;
	logic                  div_ovf;
	rlgm_pkg::lane_side_t  div_side;

	rlgm_div u_div (
		.clk      (clk),
		.adv      (adv),
		.num      (num_s2),
		.den      (den_s2),
		.side_in  (side_s2),
		.quot     (div_q),
		.ovf      (div_ovf),
		.side_out (div_side)
	);

	// s3: factor, clamped to -8..1
	logic signed [FW:0]    factor_diff;
	logic signed [FW-1:0]  factor_s3;
	rlgm_pkg::lane_side_t  side_s3;

	assign factor_diff = rlgm_pkg::ONE_Q14 - $signed({1'b0, div_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_side.forced) begin
				factor_s3 <= rlgm_pkg::ONE_Q14;
			end else if (div_ovf || (div_q > rlgm_pkg::Q_MAX)) begin
				factor_s3 <= rlgm_pkg::FACTOR_MIN;
			end else begin
				factor_s3 <= factor_diff[FW-1:0];
			end
			side_s3 <= div_side;
		end
	end

	// s4: cmd * F and rate * D
	logic signed [33:0] prod1_s4;
	logic signed [34:0] damp_s4;
	logic               zero_s4;
	logic [15:0]        weight_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod1_s4  <= $signed(side_s3.cmd) * factor_s3;
			damp_s4   <= $signed(side_s3.rate) * $signed(side_s3.cfg.damp);
			zero_s4   <= side_s3.cmd == '0;
			weight_s4 <= side_s3.cfg.weight;
		end
	end

	// s5: times command weight
	logic signed [50:0] prod2_s5;
	logic signed [34:0] damp_s5;
	logic               zero_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod2_s5 <= prod1_s4 * $signed({1'b0, weight_s4});
			damp_s5  <= damp_s4;
			zero_s5  <= zero_s4;
		end
	end

	// s6: round half up and pick the term
	logic signed [51:0] cmd_sum, cmd_rnd;
	logic signed [35:0] damp_sum, damp_rnd;
	logic signed [TW-1:0] term_s6;

	always_comb begin
		cmd_sum  = prod2_s5 + CMD_HALF;
		cmd_rnd  = cmd_sum >>> 31;
		damp_sum = damp_s5 + DAMP_HALF;
		damp_rnd = damp_sum >>> 14;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s6 <= zero_s5 ? damp_rnd[TW-1:0] : cmd_rnd[TW-1:0];
		end
	end

	assign term = term_s6;

endmodule

`default_nettype wire

>>> sv/rlgm_merge.sv
// Mixing stage: combines the three axis terms into per-engine deflections, one per cycle.
// Depends on rlgm_pkg.
`default_nettype none

module rlgm_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  rlgm_pkg::mix_in_t   mix,
	output logic                ready,
	output logic                strobe,
	output rlgm_pkg::result_t   result
);

	localparam int TW = rlgm_pkg::TERM_W;
	localparam int EW = rlgm_pkg::ENG_W;

	logic                  active_q;
	logic [EW-1:0]         eng_q;
	rlgm_pkg::mode_t       mode_q;
	logic signed [TW-1:0]  pt_q, yt_q, rt_q;
	logic                  strobe_q;
	rlgm_pkg::result_t     result_q;

	logic                  last_now;
	rlgm_pkg::roll_op_t    op;
	logic signed [TW:0]    y_sum;
	logic signed [TW:0]    x_val;

	always_comb begin
		last_now = (mode_q == rlgm_pkg::MODE_SINGLE) || (eng_q == rlgm_pkg::LAST_ENGINE);
		ready    = !active_q || last_now;
		op       = rlgm_pkg::roll_op(mode_q, eng_q);
		x_val    = yt_q;
		case (op)
			rlgm_pkg::ROLL_ADD: y_sum = pt_q + rt_q;
			rlgm_pkg::ROLL_SUB: y_sum = pt_q - rt_q;
			default:            y_sum = pt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			eng_q    <= '0;
			mode_q   <= rlgm_pkg::MODE_FIRST;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (load) begin
				active_q <= 1'b1;
				eng_q    <= '0;
				mode_q   <= mix.mode;
			end else if (active_q) begin
				if (last_now) begin
					active_q <= 1'b0;
				end else begin
					eng_q <= eng_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pt_q <= mix.pt;
			yt_q <= mix.yt;
			rt_q <= mix.rt;
		end
		if (active_q) begin
			result_q.engine_index <= eng_q;
			result_q.deflect_x    <= rlgm_pkg::sat16(x_val);
			result_q.deflect_y    <= rlgm_pkg::sat16(y_sum);
			result_q.last_engine  <= last_now;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

`default_nettype wire

>>> sv/rate_limited_gimbal_mixer_core.sv
// Top level of the rate-limited gimbal mixer: config registers, three axis lanes, mixer.
// Depends on rlgm_pkg, rlgm_lane, rlgm_div and rlgm_merge.
//
// A transaction is taken on a clock edge with start high and busy low; each engine result
// is shown for exactly one cycle with strobe high and cannot be held off. Single-engine
// mode gives one result per transaction and takes a new transaction every cycle. The
// five-engine modes give five results on consecutive cycles, engine 0 first, last_engine
// set on engine 4, so the single result port sets the pace of five-engine transactions;
// busy is high while a transaction waits at the lane outputs for the mixer to finish an
// earlier one. Between the accepting edge and the rise of strobe lie the 25 lane stages
// (mostly the 19-stage restoring divider of each axis), the mixer load and the output
// register. cfg_ready is always high; write registers only while no transaction is in
// flight.
`default_nettype none

module rate_limited_gimbal_mixer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rlgm_pkg::item_t    item,
	output logic               strobe,
	output rlgm_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [1:0]         cfg_data
);

	localparam int LAT = rlgm_pkg::LANE_LAT;
	localparam int TW  = rlgm_pkg::TERM_W;
	localparam int CW  = rlgm_pkg::CMD_W;

	rlgm_pkg::mode_t stage_mode_q;
	logic            pitch_en_q;
	logic            yaw_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_mode_q <= rlgm_pkg::MODE_FIRST;
			pitch_en_q   <= 1'b1;
			yaw_en_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				// code 3 folds onto single engine
				rlgm_pkg::CFG_STAGE_MODE: stage_mode_q <= cfg_data[1] ?
					rlgm_pkg::MODE_SINGLE : rlgm_pkg::mode_t'(cfg_data);
				rlgm_pkg::CFG_PITCH_EN:   pitch_en_q <= cfg_data[0];
				rlgm_pkg::CFG_YAW_EN:     yaw_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Pipeline control: all lane stages move together
	logic [LAT-1:0]   vld_s;
	rlgm_pkg::mode_t  mode_s [0:LAT-1];
	logic             mix_ready;
	logic             adv;
	logic             accept;

	assign adv    = !(vld_s[LAT-1] && !mix_ready);
	assign busy   = !adv;
	assign accept = start && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s[0] <= stage_mode_q;
			for (int k = 1; k < LAT; k++) begin
				mode_s[k] <= mode_s[k-1];
			end
		end
	end

	// Per-axis commands and constants
	logic                 single, first;
	logic signed [CW-1:0] pitch_cmd_eff, yaw_cmd_eff;
	rlgm_pkg::lane_cfg_t  cfg_p, cfg_y, cfg_r;

	always_comb begin
		single        = stage_mode_q == rlgm_pkg::MODE_SINGLE;
		first         = stage_mode_q == rlgm_pkg::MODE_FIRST;
		pitch_cmd_eff = (single && !pitch_en_q) ? '0 : item.pitch_cmd;
		yaw_cmd_eff   = (single && !yaw_en_q) ? '0 : item.yaw_cmd;

		cfg_p.gain   = rlgm_pkg::GAIN_0175;
		cfg_p.rule   = rlgm_pkg::RULE_SAME;
		cfg_p.weight = rlgm_pkg::WEIGHT_009;
		cfg_p.damp   = first ? rlgm_pkg::DAMP_24 : rlgm_pkg::DAMP_19;

		// yaw: mirrored sign rule, damping of opposite sign
		cfg_y.gain   = rlgm_pkg::GAIN_0175;
		cfg_y.rule   = rlgm_pkg::RULE_OPPOSITE;
		cfg_y.weight = rlgm_pkg::WEIGHT_009;
		cfg_y.damp   = first ? -rlgm_pkg::DAMP_24 : -rlgm_pkg::DAMP_19;

		if (first) begin
			cfg_r.gain   = rlgm_pkg::GAIN_0175;
			cfg_r.rule   = rlgm_pkg::RULE_SAME;
			cfg_r.weight = rlgm_pkg::WEIGHT_060;
			cfg_r.damp   = rlgm_pkg::DAMP_285;
		end else begin
			cfg_r.gain   = rlgm_pkg::GAIN_035;
			cfg_r.rule   = rlgm_pkg::RULE_NONE;
			cfg_r.weight = rlgm_pkg::WEIGHT_009;
			cfg_r.damp   = rlgm_pkg::DAMP_198;
		end
	end

	logic signed [TW-1:0] pt, yt, rt;

	rlgm_lane u_lane_pitch (
		.clk  (clk),
		.adv  (adv),
		.cmd  (pitch_cmd_eff),
		.rate (item.rate_pitch),
		.cfg  (cfg_p),
		.term (pt)
	);

	rlgm_lane u_lane_yaw (
		.clk  (clk),
		.adv  (adv),
		.cmd  (yaw_cmd_eff),
		.rate (item.rate_yaw),
		.cfg  (cfg_y),
		.term (yt)
	);

	rlgm_lane u_lane_roll (
		.clk  (clk),
		.adv  (adv),
		.cmd  (item.roll_cmd),
		.rate (item.rate_roll),
		.cfg  (cfg_r),
		.term (rt)
	);

	rlgm_pkg::mix_in_t mix;

	always_comb begin
		mix.mode = mode_s[LAT-1];
		mix.pt   = pt;
		mix.yt   = yt;
		mix.rt   = rt;
	end

	rlgm_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (vld_s[LAT-1] && adv),
		.mix    (mix),
		.ready  (mix_ready),
		.strobe (strobe),
		.result (result)
	);

endmodule

`default_nettype wire

>>> sv/rlgm_checker.sv
// Port-level checker for the gimbal mixer result stream, bound to the top level.
// Depends on rlgm_pkg and rate_limited_gimbal_mixer_core_assert.svh.
`default_nettype none

`include "rate_limited_gimbal_mixer_core_assert.svh"

module rlgm_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               strobe,
	input rlgm_pkg::result_t  result
);

	// engines of one transaction come out on consecutive cycles, in order
	`RLGM_CHECK_NEXT(a_burst_unbroken, strobe && !result.last_engine, strobe)
	`RLGM_CHECK_NEXT(a_engine_order, strobe && !result.last_engine, result.engine_index == $past(result.engine_index) + 3'd1)
	`RLGM_CHECK_NOW(a_last_flag, strobe && result.engine_index == rlgm_pkg::LAST_ENGINE, result.last_engine)
	`RLGM_CHECK_NOW(a_last_index, strobe && result.last_engine, result.engine_index == '0 || result.engine_index == rlgm_pkg::LAST_ENGINE)

endmodule

bind rate_limited_gimbal_mixer_core rlgm_checker u_rlgm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.result (result)
);

`default_nettype wire

>>> test/tb_rate_limited_gimbal_mixer_core.sv
// Testbench for rate_limited_gimbal_mixer_core: directed and random items in every stage mode,
// each checked per engine against a behavioral predictor of the rate-limited mix.
// Depends on rlgm_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_rate_limited_gimbal_mixer_core;

	localparam int         NUM_ENGINES    = 5;
	localparam logic [1:0] MODE_SPARE     = 2'd3;   // unused encoding, acts as single engine
	localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;   // no register behind it

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	rlgm_pkg::item_t   item = '0;
	logic              strobe;
	rlgm_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [1:0]        cfg_data = '0;

	// shadow of the register file
	logic [1:0] mode_reg = rlgm_pkg::MODE_FIRST;
	logic       pitch_en_reg = 1'b1;
	logic       yaw_en_reg = 1'b1;

	rlgm_pkg::result_t deflection_queue[$];
	int                err_count = 0;
	int                idle_pct = 0;

	rate_limited_gimbal_mixer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ---------------- predictor ----------------

	// Q.14 limiting factor, clamped at -8.0
	function automatic longint limit_factor(longint c, longint r, longint gain,
			rlgm_pkg::rule_t rule);
		longint unsigned ac;
		longint unsigned ar;
		longint unsigned g;
		longint unsigned q;
		if (rule == rlgm_pkg::RULE_SAME && ((c > 0 && r > 0) || (c < 0 && r < 0)))
			return rlgm_pkg::ONE_Q14;
		if (rule == rlgm_pkg::RULE_OPPOSITE && ((c > 0 && r < 0) || (c < 0 && r > 0)))
			return rlgm_pkg::ONE_Q14;
		ac = (c < 0) ? -c : c;
		ar = (r < 0) ? -r : r;
		g = gain;
		q = (ar << 33) / (g * ac);
		if (q > rlgm_pkg::Q_MAX)
			return rlgm_pkg::FACTOR_MIN;
		return longint'(rlgm_pkg::ONE_Q14) - longint'(q);
	endfunction

	// round to nearest, ties up
	function automatic longint round_shift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint axis_term(longint c, longint r, longint gain,
			rlgm_pkg::rule_t rule, longint weight, longint damp);
		if (c == 0)
			return round_shift(r * damp, 14);
		return round_shift(c * limit_factor(c, r, gain, rule) * weight, 31);
	endfunction

	function automatic logic signed [15:0] clamp_q14(longint v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	task automatic predict_deflections(input rlgm_pkg::item_t it);
		longint            pc, yc, rc, rp, ry, rr;
		longint            pt, yt, rt, dpy;
		int                roll_sign[NUM_ENGINES];
		bit                single;
		rlgm_pkg::result_t r;
		pc = it.pitch_cmd;
		yc = it.yaw_cmd;
		rc = it.roll_cmd;
		rp = it.rate_pitch;
		ry = it.rate_yaw;
		rr = it.rate_roll;
		single = !(mode_reg == rlgm_pkg::MODE_FIRST || mode_reg == rlgm_pkg::MODE_UPPER);
		if (single) begin
			if (!pitch_en_reg)
				pc = 0;
			if (!yaw_en_reg)
				yc = 0;
		end
		dpy = (mode_reg == rlgm_pkg::MODE_FIRST) ? longint'(rlgm_pkg::DAMP_24) :
			longint'(rlgm_pkg::DAMP_19);
		pt = axis_term(pc, rp, rlgm_pkg::GAIN_0175, rlgm_pkg::RULE_SAME,
			rlgm_pkg::WEIGHT_009, dpy);
		yt = axis_term(yc, ry, rlgm_pkg::GAIN_0175, rlgm_pkg::RULE_OPPOSITE,
			rlgm_pkg::WEIGHT_009, -dpy);
		if (single) begin
			r.engine_index = '0;
			r.deflect_x = clamp_q14(yt);
			r.deflect_y = clamp_q14(pt);
			r.last_engine = 1'b1;
			deflection_queue.push_back(r);
		end else begin
			if (mode_reg == rlgm_pkg::MODE_FIRST) begin
				rt = axis_term(rc, rr, rlgm_pkg::GAIN_0175, rlgm_pkg::RULE_SAME,
					rlgm_pkg::WEIGHT_060, rlgm_pkg::DAMP_285);
				roll_sign = '{1, -1, -1, 1, 0};
			end else begin
				rt = axis_term(rc, rr, rlgm_pkg::GAIN_035, rlgm_pkg::RULE_NONE,
					rlgm_pkg::WEIGHT_009, rlgm_pkg::DAMP_198);
				roll_sign = '{-1, 1, -1, 1, 0};
			end
			for (int k = 0; k < NUM_ENGINES; k++) begin
				r.engine_index = rlgm_pkg::ENG_W'(k);
				r.deflect_x = clamp_q14(yt);
				r.deflect_y = clamp_q14(pt + roll_sign[k] * rt);
				r.last_engine = (k == NUM_ENGINES - 1);
				deflection_queue.push_back(r);
			end
		end
	endtask

	// ---------------- result checker ----------------

	always @(posedge clk) begin
		rlgm_pkg::result_t want;
		if (arst_n && strobe) begin
			if (deflection_queue.size() == 0) begin
				$error("unexpected result, engine_index %0d", result.engine_index);
				err_count++;
			end else begin
				want = deflection_queue.pop_front();
				if (result.engine_index !== want.engine_index) begin
					$error("engine_index expected %0d got %0d",
						want.engine_index, result.engine_index);
					err_count++;
				end
				if (result.deflect_x !== want.deflect_x) begin
					$error("deflect_x expected %0d got %0d", want.deflect_x, result.deflect_x);
					err_count++;
				end
				if (result.deflect_y !== want.deflect_y) begin
					$error("deflect_y expected %0d got %0d", want.deflect_y, result.deflect_y);
					err_count++;
				end
				if (result.last_engine !== want.last_engine) begin
					$error("last_engine expected %0d got %0d",
						want.last_engine, result.last_engine);
					err_count++;
				end
			end
		end
	end

	// ---------------- drivers ----------------

	// start stays high between back-to-back transactions; lowered only for a gap
	task automatic send_item(input rlgm_pkg::item_t it);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		predict_deflections(it);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (deflection_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rlgm_pkg::CFG_STAGE_MODE: mode_reg = data;
			rlgm_pkg::CFG_PITCH_EN:   pitch_en_reg = data[0];
			rlgm_pkg::CFG_YAW_EN:     yaw_en_reg = data[0];
			default: ;
		endcase
	endtask

	// only called with nothing in flight; upper data bit of the enables is junk
	task automatic set_config(input logic [1:0] mode, input bit pen, input bit yen,
			input bit poke_unused);
		write_reg(rlgm_pkg::CFG_STAGE_MODE, mode);
		write_reg(rlgm_pkg::CFG_PITCH_EN, {1'($urandom), pen});
		write_reg(rlgm_pkg::CFG_YAW_EN, {1'($urandom), yen});
		if (poke_unused)
			write_reg(CFG_UNUSED_IDX, 2'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// ---------------- stimulus ----------------

	function automatic rlgm_pkg::item_t mk_item(int p, int y, int r, int rp, int ry, int rr);
		return '{16'(p), 16'(y), 16'(r), 16'(rp), 16'(ry), 16'(rr)};
	endfunction

	function automatic rlgm_pkg::item_t directed_item(int k);
		case (k)
			0:  return mk_item(0, 0, 0, 0, 0, 0);
			1:  return mk_item(32767, 32767, 32767, 32767, 32767, 32767);
			2:  return mk_item(-32768, -32768, -32768, -32768, -32768, -32768);
			3:  return mk_item(32767, 32767, 32767, -32768, -32768, -32768);
			4:  return mk_item(-32768, -32768, -32768, 32767, 32767, 32767);
			5:  return mk_item(32767, -32768, 32767, 16, 16, 16);
			6:  return mk_item(1, -1, 1, -1, -1, -1);           // factor pinned at -8
			7:  return mk_item(0, 0, 0, 32767, 32767, 32767);   // damping only
			8:  return mk_item(0, 0, 0, -32768, -32768, -32768);
			9:  return mk_item(20000, -20000, 20000, -3000, -3000, 3000);
			10: return mk_item(-32768, 32767, -1, 0, 0, 0);
			default: return mk_item(-20000, 20000, -20000, 2500, -2500, 2500);
		endcase
	endfunction

	function automatic int rand_cmd();
		case ($urandom_range(9))
			0, 1:    return 0;
			2:       return 32767;
			3:       return -32768;
			4, 5:    return int'($urandom_range(510)) - 255;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	// in four of ten draws small against the command so the factor lands inside -8..1
	function automatic int rand_rate(int c);
		int mag;
		mag = ((c < 0) ? -c : c) / 6 + 1;
		case ($urandom_range(9))
			0, 1, 2, 3: return int'($urandom_range(2 * mag)) - mag;
			4:          return 0;
			5:          return $urandom_range(1) ? 32767 : -32768;
			default:    return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic rlgm_pkg::item_t rand_item();
		int p, y, r;
		p = rand_cmd();
		y = rand_cmd();
		r = rand_cmd();
		return mk_item(p, y, r, rand_rate(p), rand_rate(y), rand_rate(r));
	endfunction

	// ---------------- tests ----------------

	task automatic test_reset_defaults;
		for (int k = 0; k < 12; k++)
			send_item(directed_item(k));
		drain;
	endtask

	// enables outside single engine and the unused index must change nothing
	task automatic test_ignored_writes;
		set_config(rlgm_pkg::MODE_FIRST, 1'b0, 1'b0, 1'b1);
		send_item(directed_item(3));
		send_item(directed_item(9));
		drain;
	endtask

	task automatic test_upper_stage;
		set_config(rlgm_pkg::MODE_UPPER, 1'b0, 1'b1, 1'b0);
		send_item(directed_item(1));
		send_item(directed_item(2));
		send_item(directed_item(3));
		send_item(directed_item(6));
		send_item(directed_item(9));
		drain;
	endtask

	task automatic test_single_engine;
		set_config(rlgm_pkg::MODE_SINGLE, 1'b0, 1'b0, 1'b0);
		send_item(directed_item(9));
		drain;
		set_config(rlgm_pkg::MODE_SINGLE, 1'b1, 1'b0, 1'b0);
		send_item(directed_item(9));
		drain;
		set_config(rlgm_pkg::MODE_SINGLE, 1'b0, 1'b1, 1'b0);
		send_item(directed_item(3));
		drain;
		set_config(MODE_SPARE, 1'b1, 1'b1, 1'b0);
		send_item(directed_item(9));
		send_item(directed_item(4));
		drain;
	endtask

	task automatic test_random(input int total, input int pct);
		int sent;
		int n;
		idle_pct = pct;
		sent = 0;
		while (sent < total) begin
			set_config(2'($urandom), 1'($urandom), 1'($urandom), $urandom_range(3) == 0);
			n = $urandom_range(8, 24);
			if (n > total - sent)
				n = total - sent;
			for (int k = 0; k < n; k++)
				send_item(rand_item());
			sent += n;
			drain;
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_pct = 28;
		test_reset_defaults;
		test_ignored_writes;
		test_upper_stage;
		test_single_engine;
		test_random(88, 28);
		test_random(88, 63);
		test_random(80, 0);
		repeat (40) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/rlgm_pkg.sv
sv/rlgm_div.sv
sv/rlgm_lane.sv
sv/rlgm_merge.sv
sv/rate_limited_gimbal_mixer_core.sv
sv/rlgm_checker.sv
test/tb_rate_limited_gimbal_mixer_core.sv
